### src/lbps_pkg.sv
`default_nettype none

package lbps_pkg;

	localparam int LED_COUNT = 2;
	localparam int DUR_W = 14;
	localparam int STEP_W = 18;
	localparam int REP_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [LED_COUNT-1:0] LIT_DARK = 2'b00;
	localparam logic [LED_COUNT-1:0] LIT_YELLOW = 2'b01;
	localparam logic [LED_COUNT-1:0] LIT_RED = 2'b10;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_COMMAND = 1'b1;

	localparam logic [2:0] ACT_OFF = 3'd0;
	localparam logic [2:0] ACT_RED = 3'd1;
	localparam logic [2:0] ACT_YELLOW = 3'd2;
	localparam logic [2:0] ACT_RED_TW = 3'd3;
	localparam logic [2:0] ACT_YELLOW_TW = 3'd4;
	localparam logic [2:0] ACT_CROSS_TW = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLASH_ON = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLASH_OFF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CROSS_COLOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CROSS_DARK = 3'd4;

	localparam logic [DUR_W-1:0] FLASH_ON_RST = 14'd30;
	localparam logic [DUR_W-1:0] FLASH_OFF_RST = 14'd10000;
	localparam logic [DUR_W-1:0] CROSS_COLOR_RST = 14'd300;
	localparam logic [DUR_W-1:0] CROSS_DARK_RST = 14'd400;

	localparam logic [STEP_W-1:0] STEP_MAX = '1;

	typedef struct packed {
		logic [LED_COUNT-1:0] polarity;
		logic [DUR_W-1:0]     flash_on;
		logic [DUR_W-1:0]     flash_off;
		logic [DUR_W-1:0]     cross_color;
		logic [DUR_W-1:0]     cross_dark;
	} cfg_t;

	typedef struct packed {
		logic [2:0]           action;
		logic [1:0]           phase;
		logic [STEP_W-1:0]    steps;
		logic [STEP_W-1:0]    limit;
		logic [DUR_W-1:0]     ticks;
		logic [LED_COUNT-1:0] shown;
	} seq_state_t;

	function automatic logic is_pattern(input logic [2:0] act);
		return (act == ACT_RED_TW) || (act == ACT_YELLOW_TW) || (act == ACT_CROSS_TW);
	endfunction

endpackage

`default_nettype wire

### src/lbps_cfg.sv
`default_nettype none

module lbps_cfg import lbps_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DUR_W-1:0]     cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polarity <= '0;
			cfg_q.flash_on <= FLASH_ON_RST;
			cfg_q.flash_off <= FLASH_OFF_RST;
			cfg_q.cross_color <= CROSS_COLOR_RST;
			cfg_q.cross_dark <= CROSS_DARK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLARITY: cfg_q.polarity <= cfg_data[LED_COUNT-1:0];
				REG_FLASH_ON: cfg_q.flash_on <= cfg_data;
				REG_FLASH_OFF: cfg_q.flash_off <= cfg_data;
				REG_CROSS_COLOR: cfg_q.cross_color <= cfg_data;
				REG_CROSS_DARK: cfg_q.cross_dark <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### src/lbps_step.sv
`default_nettype none

module lbps_step import lbps_pkg::*; (
	input  wire seq_state_t           cur,
	input  wire cfg_t                 cfg,
	input  wire logic                 opcode,
	input  wire logic [2:0]           action_code,
	input  wire logic [REP_W-1:0]     repeat_count,
	output seq_state_t                nxt,
	output logic [LED_COUNT-1:0]      pin_levels,
	output logic [LED_COUNT-1:0]      lit_code,
	output logic                      pattern_running
);

	function automatic seq_state_t next_phase(input seq_state_t s, input cfg_t c);
		seq_state_t       r;
		logic [1:0]       ph;
		logic             last;
		logic [DUR_W-1:0] d;
		r = s;
		if ((s.limit != '0) && (s.steps >= s.limit)) begin
			r = '0;
		end else begin
			if (s.action == ACT_CROSS_TW) begin
				ph = (s.phase == 2'd3) ? 2'd0 : s.phase;
				last = (ph == 2'd2);
				unique case (ph)
					2'd0: r.shown = LIT_RED;
					2'd1: r.shown = LIT_YELLOW;
					default: r.shown = LIT_DARK;
				endcase
				d = (ph == 2'd2) ? c.cross_dark : c.cross_color;
			end else begin
				ph = {1'b0, s.phase[0]};
				last = s.phase[0];
				if (ph == 2'd0) begin
					r.shown = (s.action == ACT_RED_TW) ? LIT_RED : LIT_YELLOW;
					d = c.flash_on;
				end else begin
					r.shown = LIT_DARK;
					d = c.flash_off;
				end
			end
			r.ticks = (d == '0) ? DUR_W'(1) : d;
			r.phase = last ? 2'd0 : ph + 2'd1;
			if (s.steps != STEP_MAX) begin
				r.steps = s.steps + STEP_W'(1);
			end
		end
		return r;
	endfunction

	logic [STEP_W-1:0] limit_calc;
	logic [DUR_W-1:0]  ticks_dec;

	assign limit_calc = {1'b0, repeat_count, 1'b0}
		+ ((action_code == ACT_CROSS_TW) ? {2'b00, repeat_count} : STEP_W'(0));
	assign ticks_dec = (cur.ticks != '0) ? cur.ticks - DUR_W'(1) : '0;

	always_comb begin
		nxt = cur;
		if (opcode == OP_COMMAND) begin
			nxt = '0;
			nxt.action = action_code;
			unique case (action_code)
				ACT_RED: nxt.shown = LIT_RED;
				ACT_YELLOW: nxt.shown = LIT_YELLOW;
				ACT_RED_TW, ACT_YELLOW_TW, ACT_CROSS_TW: begin
					nxt.limit = limit_calc;
					nxt = next_phase(nxt, cfg);
				end
				default: ;
			endcase
		end else if (is_pattern(cur.action)) begin
			nxt.ticks = ticks_dec;
			if (ticks_dec == '0) begin
				nxt = next_phase(nxt, cfg);
			end
		end
	end

	assign lit_code = nxt.shown;
	assign pin_levels = ~(nxt.shown ^ cfg.polarity);
	assign pattern_running = is_pattern(nxt.action);

endmodule

`default_nettype wire

### src/led_blink_pattern_sequencer.sv
`default_nettype none

// Two-LED blink sequencer, yellow on bit 0 and red on bit 1. Each input transfer is a 1 ms tick
// or a command, and each gives exactly one output transfer with the pin levels, the logical lit
// code and the running flag after that item. An item passes through the input register and then
// through the step logic into the output register. A new item is taken every cycle; the only
// limit is the output register, which holds while out_stall is high. Registers are written
// through cfg_we, cfg_index and cfg_data; the user must write them only while no item is in
// flight; the block does not enforce it. New phase lengths take effect at the next phase start.

module led_blink_pattern_sequencer import lbps_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DUR_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 opcode,
	input  wire logic [2:0]           action_code,
	input  wire logic [REP_W-1:0]     repeat_count,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [LED_COUNT-1:0]      pin_levels,
	output logic [LED_COUNT-1:0]      lit_code,
	output logic                      pattern_running
);

	cfg_t                 cfg;
	seq_state_t           state_q;
	seq_state_t           state_nxt;
	logic                 valid_s1;
	logic                 opcode_s1;
	logic [2:0]           action_s1;
	logic [REP_W-1:0]     repeat_s1;
	logic                 out_valid_q;
	logic [LED_COUNT-1:0] pin_levels_q;
	logic [LED_COUNT-1:0] lit_code_q;
	logic                 running_q;
	logic [LED_COUNT-1:0] pin_nxt;
	logic [LED_COUNT-1:0] lit_nxt;
	logic                 running_nxt;
	logic                 in_take;
	logic                 advance;

	lbps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lbps_step u_step (
		.cur             (state_q),
		.cfg             (cfg),
		.opcode          (opcode_s1),
		.action_code     (action_s1),
		.repeat_count    (repeat_s1),
		.nxt             (state_nxt),
		.pin_levels      (pin_nxt),
		.lit_code        (lit_nxt),
		.pattern_running (running_nxt)
	);

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1 <= opcode;
			action_s1 <= action_code;
			repeat_s1 <= repeat_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pin_levels_q <= pin_nxt;
			lit_code_q <= lit_nxt;
			running_q <= running_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign pin_levels = pin_levels_q;
	assign lit_code = lit_code_q;
	assign pattern_running = running_q;

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!is_pattern(state_q.action) |-> (state_q.ticks == '0) && (state_q.phase == 2'd0))
		else $error("idle or steady state holds leftover phase state");

	a_run_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		is_pattern(state_q.action) |-> (state_q.ticks != '0) && (state_q.phase != 2'd3))
		else $error("running pattern without time left in its phase");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.limit != '0) |-> (state_q.steps <= state_q.limit))
		else $error("phase count ran past its limit");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item did not reach the output register");

endmodule

`default_nettype wire

### bench/tb_led_blink_pattern_sequencer.sv
module tb_led_blink_pattern_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	import lbps_pkg::*;

	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 150;

	typedef struct packed {
		logic             op;
		logic [2:0]       act;
		logic [REP_W-1:0] reps;
	} seq_item_t;

	typedef struct packed {
		logic [LED_COUNT-1:0] pins;
		logic [LED_COUNT-1:0] lit;
		logic                 running;
	} led_view_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_POLARITY;
	logic [DUR_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 opcode = OP_TICK;
	logic [2:0]           action_code = ACT_OFF;
	logic [REP_W-1:0]     repeat_count = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [LED_COUNT-1:0] pin_levels;
	logic [LED_COUNT-1:0] lit_code;
	logic                 pattern_running;

	led_blink_pattern_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.action_code(action_code),
		.repeat_count(repeat_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pin_levels(pin_levels),
		.lit_code(lit_code),
		.pattern_running(pattern_running)
	);

	always #10 clk = ~clk;

	seq_item_t items_to_send[$];
	led_view_t led_views_due[$];

	logic                 in_took = 1'b0;
	bit                   sender_gaps = 1'b1;
	bit                   recv_gaps = 1'b1;
	bit                   hold_arm = 1'b0;
	bit                   hold_done = 1'b0;
	int                   hold_left = 0;
	int                   fail_count = 0;
	int                   results_checked = 0;
	int                   cycle_count = 0;

	logic [LED_COUNT-1:0] reg_pol = '0;
	logic [DUR_W-1:0]     reg_flash_on = FLASH_ON_RST;
	logic [DUR_W-1:0]     reg_flash_off = FLASH_OFF_RST;
	logic [DUR_W-1:0]     reg_cross_color = CROSS_COLOR_RST;
	logic [DUR_W-1:0]     reg_cross_dark = CROSS_DARK_RST;

	logic [2:0]           seq_act = ACT_OFF;
	logic [1:0]           seq_phase = '0;
	logic [STEP_W-1:0]    seq_steps = '0;
	logic [STEP_W-1:0]    seq_limit = '0;
	logic [DUR_W-1:0]     seq_ticks = '0;
	logic [LED_COUNT-1:0] seq_shown = LIT_DARK;

	function automatic bit twinkling();
		return seq_act >= ACT_RED_TW && seq_act <= ACT_CROSS_TW;
	endfunction

	function automatic int phases_of(input logic [2:0] act);
		return (act == ACT_CROSS_TW) ? 3 : 2;
	endfunction

	function automatic logic [LED_COUNT-1:0] phase_lights(input logic [2:0] act, input int ph);
		if (ph == 0)
			return (act == ACT_YELLOW_TW) ? LIT_YELLOW : LIT_RED;
		if (ph == 1 && act == ACT_CROSS_TW)
			return LIT_YELLOW;
		return LIT_DARK;
	endfunction

	function automatic logic [DUR_W-1:0] phase_ticks(input logic [2:0] act, input int ph);
		logic [DUR_W-1:0] d;
		if (act == ACT_CROSS_TW)
			d = (ph < 2) ? reg_cross_color : reg_cross_dark;
		else
			d = (ph == 0) ? reg_flash_on : reg_flash_off;
		return (d == 0) ? DUR_W'(1) : d;
	endfunction

	task automatic clear_sequence();
		seq_phase = '0;
		seq_steps = '0;
		seq_limit = '0;
		seq_ticks = '0;
		seq_shown = LIT_DARK;
	endtask

	task automatic start_phase();
		int n;
		int ph;
		if (seq_limit != 0 && seq_steps >= seq_limit) begin
			seq_act = ACT_OFF;
			clear_sequence();
		end else begin
			n = phases_of(seq_act);
			ph = int'(seq_phase) % n;
			seq_shown = phase_lights(seq_act, ph);
			seq_ticks = phase_ticks(seq_act, ph);
			seq_phase = 2'((ph + 1) % n);
			if (seq_steps != STEP_MAX)
				seq_steps = seq_steps + 1'b1;
		end
	endtask

	task automatic step_sequencer(input logic op, input logic [2:0] act,
			input logic [REP_W-1:0] reps, output led_view_t v);
		if (op == OP_COMMAND) begin
			clear_sequence();
			seq_act = act;
			case (act)
				ACT_RED: begin
					seq_shown = LIT_RED;
				end
				ACT_YELLOW: begin
					seq_shown = LIT_YELLOW;
				end
				ACT_RED_TW, ACT_YELLOW_TW, ACT_CROSS_TW: begin
					seq_limit = STEP_W'(reps) * STEP_W'(phases_of(act));
					start_phase();
				end
				default: begin
				end
			endcase
		end else if (twinkling()) begin
			if (seq_ticks != 0)
				seq_ticks = seq_ticks - 1'b1;
			if (seq_ticks == 0)
				start_phase();
		end
		v.pins = ~(seq_shown ^ reg_pol);
		v.lit = seq_shown;
		v.running = twinkling();
	endtask

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		if (fail_count < 100)
			$display("ERROR result %0d %s: got %0h, expected %0h", results_checked, what, got,
				exp_val);
		fail_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_POLARITY: reg_pol = data[LED_COUNT-1:0];
			REG_FLASH_ON: reg_flash_on = data;
			REG_FLASH_OFF: reg_flash_off = data;
			REG_CROSS_COLOR: reg_cross_color = data;
			REG_CROSS_DARK: reg_cross_dark = data;
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [LED_COUNT-1:0] pol, input int fon, input int foff,
			input int ccol, input int cdark);
		write_reg(REG_POLARITY, {12'($urandom), pol});
		write_reg(REG_FLASH_ON, DUR_W'(fon));
		write_reg(REG_FLASH_OFF, DUR_W'(foff));
		write_reg(REG_CROSS_COLOR, DUR_W'(ccol));
		write_reg(REG_CROSS_DARK, DUR_W'(cdark));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// The check runs just after the falling edge so that the driver's updates have settled.
	task automatic wait_drained();
		do begin
			@(negedge clk);
			#1;
		end while (items_to_send.size() != 0 || in_valid || led_views_due.size() != 0);
	endtask

	function automatic seq_item_t make_item(input logic op, input logic [2:0] act,
			input logic [REP_W-1:0] reps);
		seq_item_t it;
		it.op = op;
		it.act = act;
		it.reps = reps;
		return it;
	endfunction

	function automatic seq_item_t random_item();
		seq_item_t it;
		it.op = ($urandom_range(0, 99) < 15) ? OP_COMMAND : OP_TICK;
		it.act = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(3, 5)) : 3'($urandom_range(0, 7));
		case ($urandom_range(0, 9))
			0: it.reps = REP_W'($urandom);
			1: it.reps = '0;
			default: it.reps = REP_W'($urandom_range(1, 4));
		endcase
		return it;
	endfunction

	always @(negedge clk) begin : drive
		seq_item_t nxt;
		if (!in_valid || in_took) begin
			if (items_to_send.size() != 0 && !(sender_gaps && $urandom_range(0, 99) < 9)) begin
				nxt = items_to_send.pop_front();
				in_valid <= 1'b1;
				opcode <= nxt.op;
				action_code <= nxt.act;
				repeat_count <= nxt.reps;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receive
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= recv_gaps && ($urandom_range(0, 99) < 9);
		end
	end

	always @(posedge clk) begin : watch
		led_view_t predicted;
		led_view_t oldest;
		led_view_t seen;
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				step_sequencer(opcode, action_code, repeat_count, predicted);
				led_views_due.push_back(predicted);
			end
			if (out_valid && !out_stall) begin
				seen = '{pins: pin_levels, lit: lit_code, running: pattern_running};
				if (led_views_due.size() == 0) begin
					report_mismatch("transfer with nothing expected", seen, 0);
				end else begin
					oldest = led_views_due.pop_front();
					if (seen.pins !== oldest.pins)
						report_mismatch("pin_levels", seen.pins, oldest.pins);
					if (seen.lit !== oldest.lit)
						report_mismatch("lit_code", seen.lit, oldest.lit);
					if (seen.running !== oldest.running)
						report_mismatch("pattern_running", seen.running, oldest.running);
				end
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** led_blink_pattern_sequencer: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		int n;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset durations and polarity are still in force here.
		items_to_send.push_back(make_item(OP_COMMAND, ACT_RED_TW, 16'd2));
		items_to_send.push_back(make_item(OP_TICK, ACT_OFF, 16'd0));
		wait_drained();

		// A cross color length of zero must behave as a single tick.
		program_regs(2'b01, 2, 1, 0, 3);
		items_to_send.push_back(make_item(OP_COMMAND, ACT_RED, 16'd0));
		items_to_send.push_back(make_item(OP_TICK, ACT_SPARE7, 16'hFFFF));
		items_to_send.push_back(make_item(OP_COMMAND, ACT_YELLOW, 16'hFFFF));
		items_to_send.push_back(make_item(OP_COMMAND, ACT_OFF, 16'd0));
		items_to_send.push_back(make_item(OP_TICK, ACT_OFF, 16'd0));
		items_to_send.push_back(make_item(OP_COMMAND, ACT_RED_TW, 16'd1));
		repeat (3) items_to_send.push_back(make_item(OP_TICK, ACT_OFF, 16'd0));
		items_to_send.push_back(make_item(OP_COMMAND, ACT_YELLOW_TW, 16'd0));
		repeat (3) items_to_send.push_back(make_item(OP_TICK, ACT_OFF, 16'd0));
		items_to_send.push_back(make_item(OP_COMMAND, ACT_CROSS_TW, 16'hFFFF));
		repeat (3) items_to_send.push_back(make_item(OP_TICK, ACT_OFF, 16'd0));
		items_to_send.push_back(make_item(OP_COMMAND, ACT_SPARE6, 16'd5));
		items_to_send.push_back(make_item(OP_TICK, ACT_OFF, 16'd0));
		items_to_send.push_back(make_item(OP_COMMAND, ACT_SPARE7, 16'd0));
		items_to_send.push_back(make_item(OP_TICK, ACT_OFF, 16'd0));
		wait_drained();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: program_regs(2'b11, 1, 1, 1, 1);
				1: program_regs(2'b00, $urandom_range(1, 6), $urandom_range(1, 6),
					$urandom_range(1, 6), $urandom_range(1, 6));
				2: program_regs(2'b10, 16383, 0, 1, 16383);
				3: program_regs(2'($urandom), $urandom_range(0, 8), $urandom_range(0, 8),
					$urandom_range(0, 8), $urandom_range(0, 8));
				default: program_regs(2'($urandom), $urandom_range(1, 4), $urandom_range(1, 4),
					$urandom_range(1, 4), $urandom_range(1, 4));
			endcase
			sender_gaps = (p != 0);
			recv_gaps = (p != 0);
			if (p == 1)
				hold_arm = 1'b1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 3 && n == ITEMS_PER_PHASE / 2)
					wait_drained();
				items_to_send.push_back(random_item());
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("** led_blink_pattern_sequencer: PASSED **");
		else
			$display("** led_blink_pattern_sequencer: FAILED **");
		$finish;
	end

endmodule
